/* hdl/quat_scale_translate_matrix_assert.svh */
// Assertion macros for the quaternion matrix block and its checker.
`ifndef QUAT_SCALE_TRANSLATE_MATRIX_ASSERT_SVH
`define QUAT_SCALE_TRANSLATE_MATRIX_ASSERT_SVH

// Clocked on clk, switched off while rst_n is low.
`define QSTM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked on clk, checked during reset too.
`define QSTM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* hdl/qstm_pkg.sv */
// Types and fixed-point constants of the quaternion matrix block.
package qstm_pkg;

  localparam int Q_W     = 16;              // Q2.14 quaternion, Q8.8 scale
  localparam int PROD_W  = 2 * Q_W;         // one quaternion product
  localparam int TERM_W  = PROD_W + 2;      // doubled product, two of them summed
  localparam int SCL_W   = TERM_W + Q_W;    // rotation term times scale
  localparam int DROP_W  = 20;              // 2^-36 units down to Q16.16
  localparam int RES_W   = 32;

  localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(1) << 28;

  typedef struct packed {
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] row0_col0;
    logic signed [31:0] row0_col1;
    logic signed [31:0] row0_col2;
    logic signed [31:0] row0_col3;
    logic signed [31:0] row1_col0;
    logic signed [31:0] row1_col1;
    logic signed [31:0] row1_col2;
    logic signed [31:0] row1_col3;
    logic signed [31:0] row2_col0;
    logic signed [31:0] row2_col1;
    logic signed [31:0] row2_col2;
    logic signed [31:0] row2_col3;
  } out_t;

endpackage

/* hdl/quat_scale_translate_matrix.sv */
// Quaternion, per-axis scale and translation to a 3x4 affine matrix.
//
// One request per clock: a request is taken at every rising edge with start high and
// busy low. Its matrix shows on out_data with out_valid high for exactly one cycle,
// once it has passed the product, term, scaled-term and result registers. busy is
// high only while reset is held, so the block takes a request in every cycle
// otherwise. The pipeline steps are quaternion products, doubled sums into rotation
// terms, multiplication by the axis scale, then the drop to Q16.16. The quaternion is
// not normalized; rotation terms are rounded toward minus infinity, translation is
// passed bit for bit.
module quat_scale_translate_matrix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  qstm_pkg::in_t    in_data,
  output logic             out_valid,
  output qstm_pkg::out_t   out_data
);

  localparam int NT = 9;

  logic accept;

  // stage 1: quaternion products
  logic signed [qstm_pkg::PROD_W-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [qstm_pkg::Q_W-1:0]    s1_scale_r [3];
  logic signed [31:0]                 s1_trans_r [3];
  logic                               v1_r;

  // stage 2: rotation terms, row-major
  logic signed [qstm_pkg::TERM_W-1:0] term_r   [NT];
  logic signed [qstm_pkg::TERM_W-1:0] term_nxt [NT];
  logic signed [qstm_pkg::Q_W-1:0]    s2_scale_r [3];
  logic signed [31:0]                 s2_trans_r [3];
  logic                               v2_r;

  // stage 3: scaled terms in 2^-36 units
  logic signed [qstm_pkg::SCL_W-1:0]  scl_r   [NT];
  logic signed [qstm_pkg::SCL_W-1:0]  scl_nxt [NT];
  logic signed [31:0]                 s3_trans_r [3];
  logic                               v3_r;

  // stage 4: result register
  qstm_pkg::out_t out_r, out_nxt;
  logic           out_valid_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  function automatic logic signed [qstm_pkg::TERM_W-1:0] dbl(
    input logic signed [qstm_pkg::PROD_W-1:0] p
  );
    dbl = {p[qstm_pkg::PROD_W-1], p, 1'b0};
  endfunction

  // Floor shift; |term * scale| < 2^48 leaves 30 bits, so the value fits the 32-bit result.
  function automatic logic signed [qstm_pkg::RES_W-1:0] to_q16(
    input logic signed [qstm_pkg::SCL_W-1:0] v
  );
    logic signed [qstm_pkg::SCL_W-qstm_pkg::DROP_W-1:0] sh;
    sh     = v[qstm_pkg::SCL_W-1:qstm_pkg::DROP_W];
    to_q16 = qstm_pkg::RES_W'(sh);
  endfunction

  always_ff @(posedge clk) begin
    xx_r <= $signed(in_data.quat_x) * $signed(in_data.quat_x);
    yy_r <= $signed(in_data.quat_y) * $signed(in_data.quat_y);
    zz_r <= $signed(in_data.quat_z) * $signed(in_data.quat_z);
    xy_r <= $signed(in_data.quat_x) * $signed(in_data.quat_y);
    xz_r <= $signed(in_data.quat_x) * $signed(in_data.quat_z);
    yz_r <= $signed(in_data.quat_y) * $signed(in_data.quat_z);
    wx_r <= $signed(in_data.quat_w) * $signed(in_data.quat_x);
    wy_r <= $signed(in_data.quat_w) * $signed(in_data.quat_y);
    wz_r <= $signed(in_data.quat_w) * $signed(in_data.quat_z);
    s1_scale_r[0] <= in_data.scale_x;
    s1_scale_r[1] <= in_data.scale_y;
    s1_scale_r[2] <= in_data.scale_z;
    s1_trans_r[0] <= in_data.trans_x;
    s1_trans_r[1] <= in_data.trans_y;
    s1_trans_r[2] <= in_data.trans_z;
  end

  always_comb begin
    term_nxt[0] = qstm_pkg::ONE_Q28 - dbl(yy_r) - dbl(zz_r);
    term_nxt[1] = dbl(xy_r) - dbl(wz_r);
    term_nxt[2] = dbl(xz_r) + dbl(wy_r);
    term_nxt[3] = dbl(xy_r) + dbl(wz_r);
    term_nxt[4] = qstm_pkg::ONE_Q28 - dbl(xx_r) - dbl(zz_r);
    term_nxt[5] = dbl(yz_r) - dbl(wx_r);
    term_nxt[6] = dbl(xz_r) - dbl(wy_r);
    term_nxt[7] = dbl(yz_r) + dbl(wx_r);
    term_nxt[8] = qstm_pkg::ONE_Q28 - dbl(xx_r) - dbl(yy_r);
  end

  always_ff @(posedge clk) begin
    term_r     <= term_nxt;
    s2_scale_r <= s1_scale_r;
    s2_trans_r <= s1_trans_r;
  end

  // column k % 3 takes the scale of its axis
  for (genvar k = 0; k < NT; k++) begin : g_scale
    assign scl_nxt[k] = term_r[k] * s2_scale_r[k % 3];
  end

  always_ff @(posedge clk) begin
    scl_r      <= scl_nxt;
    s3_trans_r <= s2_trans_r;
  end

  always_comb begin
    out_nxt.row0_col0 = to_q16(scl_r[0]);
    out_nxt.row0_col1 = to_q16(scl_r[1]);
    out_nxt.row0_col2 = to_q16(scl_r[2]);
    out_nxt.row0_col3 = s3_trans_r[0];
    out_nxt.row1_col0 = to_q16(scl_r[3]);
    out_nxt.row1_col1 = to_q16(scl_r[4]);
    out_nxt.row1_col2 = to_q16(scl_r[5]);
    out_nxt.row1_col3 = s3_trans_r[1];
    out_nxt.row2_col0 = to_q16(scl_r[6]);
    out_nxt.row2_col1 = to_q16(scl_r[7]);
    out_nxt.row2_col2 = to_q16(scl_r[8]);
    out_nxt.row2_col3 = s3_trans_r[2];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/qstm_checker.sv */
// Port-level checker for the quaternion matrix block, bound into the block.
`include "quat_scale_translate_matrix_assert.svh"

module qstm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input qstm_pkg::in_t  in_data,
  input logic           out_valid,
  input qstm_pkg::out_t out_data
);

  logic acc;
  logic zero_quat;

  assign acc       = start && !busy;
  assign zero_quat = (in_data.quat_x == '0) && (in_data.quat_y == '0) &&
                     (in_data.quat_z == '0) && (in_data.quat_w == '0);

  `QSTM_ASSERT(a_req_gives_result, acc |-> ##4 out_valid)
  `QSTM_ASSERT(a_result_has_req, out_valid |-> $past(acc, 4))
  `QSTM_ASSERT(a_trans_copied, out_valid |-> (out_data.row1_col3 == $past(in_data.trans_y, 4)))
  `QSTM_ASSERT(a_zero_quat_offdiag, (acc && zero_quat) |->
                ##4 (out_data.row0_col1 == '0 && out_data.row2_col0 == '0))
  `QSTM_ASSERT_ALWAYS(a_busy_in_reset, !rst_n |-> busy)

endmodule

bind quat_scale_translate_matrix qstm_checker u_qstm_checker (.*);
